### rtl/pattern_strip_filter_macros.svh
// Assertion helpers for the port checker of the filter.
`ifndef PATTERN_STRIP_FILTER_MACROS_SVH
`define PATTERN_STRIP_FILTER_MACROS_SVH

// Next-cycle implication, switched off while reset is asserted.
`define PSF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pattern_strip_filter: assertion failed");

// Next-cycle implication that stays live through reset.
`define PSF_ASSERT_NEXT_NORST(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pattern_strip_filter: reset assertion failed");

`endif

### rtl/psf_pkg.sv
package psf_pkg;

    // Pattern storage is two 64-bit registers, sixteen bytes at most
    localparam int C_MAX_PATTERN = 16;
    localparam int C_CNT_W       = $clog2(C_MAX_PATTERN);
    localparam int C_LEN_W       = 5;
    localparam int C_PAT_W       = 8 * C_MAX_PATTERN;
    localparam int C_ADDR_W      = 6;
    localparam int C_DATA_W      = 64;

    // Register reset values: CR LF "+IPD,4," with ':' as delimiter
    localparam logic [63:0]        C_PAT_LO_RST  = 64'h342C_4450_492B_0A0D;
    localparam logic [63:0]        C_PAT_HI_RST  = 64'h0000_0000_0000_002C;
    localparam logic [C_LEN_W-1:0] C_PAT_LEN_RST = 5'd9;
    localparam logic               C_SKIP_RST    = 1'b1;
    localparam logic [7:0]         C_DELIM_RST   = 8'h3A;

    typedef enum logic [2:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_HI  = 3'd1,
        REG_PAT_LEN = 3'd2,
        REG_SKIP    = 3'd3,
        REG_DELIM   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_word;

    typedef struct packed {
        logic [C_PAT_W-1:0] pattern;
        logic [C_LEN_W-1:0] pattern_length;
        logic               skip_mode;
        logic [7:0]         delimiter_byte;
    } t_cfg;

    // One item's output work: replay prefix_n pattern bytes, then maybe tail_byte
    typedef struct packed {
        logic               valid;
        logic [C_CNT_W-1:0] prefix_n;
        logic               tail;
        logic [7:0]         tail_byte;
    } t_job;

    function automatic logic [7:0] pattern_byte(input logic [C_PAT_W-1:0] pattern,
                                                 input logic [C_CNT_W-1:0] pos);
        return pattern[{pos, 3'b000} +: 8];
    endfunction

    // Length zero acts as one, anything above the maximum saturates
    function automatic logic [C_LEN_W-1:0] effective_length(input logic [C_LEN_W-1:0] len);
        logic [C_LEN_W-1:0] eff;
        if (len == '0) begin
            eff = C_LEN_W'(1);
        end else if (len > C_LEN_W'(C_MAX_PATTERN)) begin
            eff = C_LEN_W'(C_MAX_PATTERN);
        end else begin
            eff = len;
        end
        return eff;
    endfunction

endpackage

### rtl/pattern_strip_filter.sv
// Byte stream filter that deletes occurrences of a programmable pattern
// (up to 16 bytes) and, in skip mode, the bytes after it through a delimiter.
// Input channel i_in_valid/o_in_ready carries one byte per word plus a
// stream_end flag; output channel o_out_valid/i_out_ready carries the kept
// bytes, with run_last set on the final word caused by one input word.
// Bytes that may still begin the pattern are held back; a breaking byte
// releases the held bytes and then itself, and stream_end flushes them.
// An accepted word's job is registered first; its words then pass through
// the output register. Throughput: one input word per cycle while each word
// yields at most one result and the receiver does not stall. A word that
// releases n held bytes sends n+1 words through the single output register;
// the next input is taken in the cycle its last word is loaded. Words that
// yield nothing never wait on the output once the job register is free.
// When the receiver stalls, the output word holds and the input backs up
// after one pending job. Reset clears match and skip state and restores the
// default pattern, CR LF "+IPD,4," with ':' as delimiter. Configure through
// the APB port only while the stream is idle.
module pattern_strip_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  psf_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output psf_pkg::t_out_word            o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psf_pkg::C_ADDR_W-1:0]  paddr,
    input  logic [psf_pkg::C_DATA_W-1:0]  pwdata,
    output logic [psf_pkg::C_DATA_W-1:0]  prdata,
    output logic                          pready
);
    import psf_pkg::*;

    t_cfg cfg;
    t_job job;
    logic job_take;

    psf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psf_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_take  (job_take),
        .i_cfg   (cfg),
        .o_ready (o_in_ready),
        .o_job   (job)
    );

    psf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_pattern   (cfg.pattern),
        .i_out_ready (i_out_ready),
        .o_take      (job_take),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

### rtl/psf_regs.sv
module psf_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psf_pkg::C_ADDR_W-1:0]  paddr,
    input  logic [psf_pkg::C_DATA_W-1:0]  pwdata,
    output logic [psf_pkg::C_DATA_W-1:0]  prdata,
    output logic                          pready,
    output psf_pkg::t_cfg                 o_cfg
);
    import psf_pkg::*;

    logic [63:0]        r_pat_lo;
    logic [63:0]        r_pat_hi;
    logic [C_LEN_W-1:0] r_pat_len;
    logic               r_skip;
    logic [7:0]         r_delim;
    t_reg_idx           reg_idx;
    logic               wr_en;

    assign reg_idx = t_reg_idx'(paddr[C_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= C_PAT_LO_RST;
            r_pat_hi  <= C_PAT_HI_RST;
            r_pat_len <= C_PAT_LEN_RST;
            r_skip    <= C_SKIP_RST;
            r_delim   <= C_DELIM_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PAT_LO:  r_pat_lo  <= pwdata;
                REG_PAT_HI:  r_pat_hi  <= pwdata;
                REG_PAT_LEN: r_pat_len <= pwdata[C_LEN_W-1:0];
                REG_SKIP:    r_skip    <= pwdata[0];
                REG_DELIM:   r_delim   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_PAT_LO:  prdata = r_pat_lo;
            REG_PAT_HI:  prdata = r_pat_hi;
            REG_PAT_LEN: prdata = C_DATA_W'(r_pat_len);
            REG_SKIP:    prdata = C_DATA_W'(r_skip);
            REG_DELIM:   prdata = C_DATA_W'(r_delim);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.pattern        = {r_pat_hi, r_pat_lo};
    assign o_cfg.pattern_length = r_pat_len;
    assign o_cfg.skip_mode      = r_skip;
    assign o_cfg.delimiter_byte = r_delim;

endmodule

### rtl/psf_match.sv
module psf_match (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  psf_pkg::t_in_word i_word,
    input  logic              i_take,
    input  psf_pkg::t_cfg     i_cfg,
    output logic              o_ready,
    output psf_pkg::t_job     o_job
);
    import psf_pkg::*;

    logic [C_CNT_W-1:0] r_match_count;
    logic               r_skipping;
    logic [C_CNT_W-1:0] n_match_count;
    logic               n_skipping;
    logic [C_LEN_W-1:0] eff_len;
    logic [C_LEN_W-1:0] inc_count;
    logic               hit;
    logic               accept;
    logic [C_CNT_W-1:0] prefix_n;
    logic               tail;

    assign o_ready   = i_take;
    assign accept    = i_valid && i_take;
    assign eff_len   = effective_length(i_cfg.pattern_length);
    assign inc_count = C_LEN_W'(r_match_count) + C_LEN_W'(1);
    assign hit       = (i_word.in_byte == pattern_byte(i_cfg.pattern, r_match_count));

    // Compare the word against the pattern and decide what it releases
    always_comb begin
        n_match_count = r_match_count;
        n_skipping    = r_skipping;
        prefix_n      = '0;
        tail          = 1'b0;
        if (r_skipping) begin
            if (i_word.in_byte == i_cfg.delimiter_byte) begin
                n_skipping = 1'b0;
            end
        end else if (!hit) begin
            prefix_n      = r_match_count;
            tail          = 1'b1;
            n_match_count = '0;
        end else if (inc_count >= eff_len) begin
            n_match_count = '0;
            n_skipping    = i_cfg.skip_mode;
        end else begin
            n_match_count = inc_count[C_CNT_W-1:0];
        end
        // Flush the held prefix at stream end and clear match and skip state
        if (i_word.stream_end) begin
            if (!tail) begin
                prefix_n = n_match_count;
            end
            n_match_count = '0;
            n_skipping    = 1'b0;
        end
    end

    assign o_job.valid     = accept && (tail || (prefix_n != '0));
    assign o_job.prefix_n  = prefix_n;
    assign o_job.tail      = tail;
    assign o_job.tail_byte = i_word.in_byte;

    // Advance match state on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_count <= '0;
            r_skipping    <= 1'b0;
        end else if (accept) begin
            r_match_count <= n_match_count;
            r_skipping    <= n_skipping;
        end
    end

endmodule

### rtl/psf_emit.sv
module psf_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psf_pkg::t_job                 i_job,
    input  logic [psf_pkg::C_PAT_W-1:0]   i_pattern,
    input  logic                          i_out_ready,
    output logic                          o_take,
    output logic                          o_out_valid,
    output psf_pkg::t_out_word            o_out_word
);
    import psf_pkg::*;

    logic               r_busy;
    logic [C_LEN_W-1:0] r_left;
    logic [C_CNT_W-1:0] r_idx;
    logic               r_tail;
    logic [7:0]         r_byte;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic               n_busy;
    logic [C_LEN_W-1:0] n_left;
    logic [C_CNT_W-1:0] n_idx;
    logic               n_tail;
    logic [7:0]         n_byte;
    t_out_word          n_out_word;

    logic               out_load;
    logic               job_done;
    logic               is_prefix;

    assign out_load  = !r_out_valid || i_out_ready;
    assign job_done  = !r_busy || (out_load && (r_left == C_LEN_W'(1)));
    assign o_take    = job_done;
    assign is_prefix = (r_left > C_LEN_W'(r_tail));

    // Pick the next word of the current job
    always_comb begin
        n_out_word.out_byte = is_prefix ? pattern_byte(i_pattern, r_idx) : r_byte;
        n_out_word.run_last = (r_left == C_LEN_W'(1));
    end

    // Step through the job, load the next one when it ends or the stage is idle
    always_comb begin
        n_busy = r_busy;
        n_left = r_left;
        n_idx  = r_idx;
        n_tail = r_tail;
        n_byte = r_byte;
        if (out_load && r_busy) begin
            n_left = r_left - C_LEN_W'(1);
            n_idx  = r_idx + C_CNT_W'(1);
        end
        if (job_done) begin
            n_busy = i_job.valid;
            n_left = C_LEN_W'(i_job.prefix_n) + C_LEN_W'(i_job.tail);
            n_idx  = '0;
            n_tail = i_job.tail;
            n_byte = i_job.tail_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (out_load) begin
                r_out_valid <= r_busy;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_idx  <= n_idx;
        r_tail <= n_tail;
        r_byte <= n_byte;
        if (out_load) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### rtl/psf_checker.sv
`include "pattern_strip_filter_macros.svh"

module psf_port_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  psf_pkg::t_out_word            o_out_word
);
    import psf_pkg::*;

    // Reset empties the output register
    `PSF_ASSERT_NEXT_NORST(a_reset_clears_out, i_clk, !i_rst_n, !o_out_valid)

    // A stalled output word holds
    `PSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word))

    // Input back-pressure only comes from a job that still has words to send
    `PSF_ASSERT_NEXT(a_stall_has_work, i_clk, i_rst_n, !o_in_ready, o_out_valid)

    // Words of one item follow each other without a gap
    `PSF_ASSERT_NEXT(a_run_no_gap, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_word.run_last, o_out_valid)

endmodule

bind pattern_strip_filter psf_port_checker u_psf_checker (.*);
